>>> rtl/acs_pkg.sv
package acs_pkg;

  localparam int unsigned WinLen   = 6;
  localparam int unsigned FillW    = $clog2(WinLen + 1);
  localparam int unsigned SkipW    = 3;

  localparam logic [7:0] ForbiddenMask = 8'h80;
  localparam logic [7:0] StartByte     = 8'h01;
  localparam logic [5:0] HevcTypeVps   = 6'd32;
  localparam logic [4:0] AvcTypeSps    = 5'd7;

  localparam logic [SkipW-1:0] Skip3 = SkipW'(3);
  localparam logic [SkipW-1:0] Skip4 = SkipW'(4);

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    CODEC_UNKNOWN = 2'd0,
    CODEC_H264    = 2'd1,
    CODEC_H265    = 2'd2
  } codec_kind_e;

  // H.264 profile bytes that count as a real SPS
  function automatic logic profile_known(input byte_t p);
    logic hit;
    hit = 1'b0;
    case (p)
      8'd44, 8'd66, 8'd77, 8'd88, 8'd100, 8'd110, 8'd122, 8'd244: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

>>> rtl/acs_in_if.sv
interface acs_in_if;
  import acs_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/acs_out_if.sv
interface acs_out_if;
  import acs_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] codec_kind;

  modport source (output valid, output codec_kind, input ready);
  modport sink   (input valid, input codec_kind, output ready);
endinterface

>>> rtl/annexb_codec_sniffer.sv
// Channel | Dir | Payload                     | Beat
// in_i    | in  | data_byte[7:0], last_byte   | one packet byte
// out_o   | out | codec_kind[1:0]             | one verdict per packet
//
// One byte per clock; the scan of a byte finishes in the cycle it is taken.
// The verdict appears in the output register in the cycle after the last byte is taken.
// in_i.ready drops only while a verdict sits unread and out_o.ready is low.
// rst_ni (async, active low) clears the window, counters, flags and out valid.
module annexb_codec_sniffer (
  input  logic      clk_i,
  input  logic      rst_ni,
  acs_in_if.sink    in_i,
  acs_out_if.source out_o
);
  import acs_pkg::*;

  byte_t            win_q [WinLen];
  byte_t            win_d [WinLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic             vps_q, vps_d;
  logic             sps_q, sps_d;

  logic             out_valid_q;
  codec_kind_e      codec_q;
  codec_kind_e      codec_d;

  logic in_beat;
  logic full_d;
  logic start4, start3;
  byte_t hdr, nxt;
  logic vps_hit, sps_hit;

  // Output register acts as the skid: take input unless a verdict is stuck.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_beat    = in_i.valid && in_i.ready;

  // Shift the new byte in; the candidate is the oldest slot of the new window.
  always_comb begin
    for (int k = 0; k < WinLen - 1; k++) begin
      win_d[k] = win_q[k+1];
    end
    win_d[WinLen-1] = in_i.data_byte;
  end

  always_comb begin
    start4 = (win_d[0] == '0) && (win_d[1] == '0) && (win_d[2] == '0) &&
             (win_d[3] == StartByte);
    start3 = !start4 && (win_d[0] == '0) && (win_d[1] == '0) &&
             (win_d[2] == StartByte);
    hdr    = start4 ? win_d[4] : win_d[3];
    nxt    = start4 ? win_d[5] : win_d[4];
    // Forbidden bit kills the header; a VPS type takes precedence over SPS.
    vps_hit = (start4 || start3) && ((hdr & ForbiddenMask) == '0) &&
              (hdr[6:1] == HevcTypeVps);
    sps_hit = (start4 || start3) && ((hdr & ForbiddenMask) == '0) &&
              (hdr[6:1] != HevcTypeVps) && (hdr[4:0] == AvcTypeSps) &&
              profile_known(nxt);
  end

  always_comb begin
    fill_d = (fill_q == FillW'(WinLen)) ? fill_q : fill_q + FillW'(1);
    full_d = (fill_d == FillW'(WinLen));
    skip_d = skip_q;
    vps_d  = vps_q;
    sps_d  = sps_q;
    if (full_d) begin
      if (skip_q != '0) begin
        skip_d = skip_q - SkipW'(1);
      end else if (start4 || start3) begin
        // skip the rest of the start code plus the header byte
        skip_d = start4 ? Skip4 : Skip3;
        vps_d  = vps_q || vps_hit;
        sps_d  = sps_q || sps_hit;
      end
    end
    if (vps_d) begin
      codec_d = CODEC_H265;
    end else if (sps_d) begin
      codec_d = CODEC_H264;
    end else begin
      codec_d = CODEC_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinLen; k++) begin
        win_q[k] <= '0;
      end
      fill_q <= '0;
      skip_q <= '0;
      vps_q  <= 1'b0;
      sps_q  <= 1'b0;
    end else if (in_beat) begin
      if (in_i.last_byte) begin
        // packet ends: back to the reset state
        for (int k = 0; k < WinLen; k++) begin
          win_q[k] <= '0;
        end
        fill_q <= '0;
        skip_q <= '0;
        vps_q  <= 1'b0;
        sps_q  <= 1'b0;
      end else begin
        for (int k = 0; k < WinLen; k++) begin
          win_q[k] <= win_d[k];
        end
        fill_q <= fill_d;
        skip_q <= skip_d;
        vps_q  <= vps_d;
        sps_q  <= sps_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat && in_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && in_i.last_byte) begin
      codec_q <= codec_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.codec_kind = codec_q;

endmodule

>>> sim/annexb_codec_sniffer_test.sv
import acs_pkg::*;

// Tracks the scanner state for the bytes the block has taken and queues one
// verdict per packet.
class verdict_board;
  byte_t       win[WinLen];
  int unsigned fill;
  int unsigned skip;
  bit          vps;
  bit          sps;
  codec_kind_e pending[$];
  int unsigned errors;

  function new();
    errors = 0;
    clear_state();
  endfunction

  function void clear_state();
    foreach (win[k]) win[k] = '0;
    fill = 0;
    skip = 0;
    vps  = 1'b0;
    sps  = 1'b0;
  endfunction

  task report_mismatch(string what);
    $display("mismatch @%0t: %s", $time, what);
    errors++;
  endtask

  // Called for every accepted input beat.
  function void note_byte(byte_t b, logic last);
    int unsigned code_len;
    byte_t       hdr;
    byte_t       prof;
    codec_kind_e kind;
    code_len = 0;
    for (int k = 0; k < WinLen - 1; k++) win[k] = win[k + 1];
    win[WinLen - 1] = b;
    if (fill < WinLen) fill++;
    if (fill == WinLen) begin
      if (skip != 0) begin
        skip--;
      end else begin
        if (win[0] == 8'h00 && win[1] == 8'h00 && win[2] == 8'h00 && win[3] == StartByte) begin
          code_len = 4;
        end else if (win[0] == 8'h00 && win[1] == 8'h00 && win[2] == StartByte) begin
          code_len = 3;
        end
        if (code_len != 0) begin
          skip = code_len;
          hdr  = win[code_len];
          prof = win[code_len + 1];
          if ((hdr & ForbiddenMask) == 8'h00) begin
            if (hdr[6:1] == HevcTypeVps) begin
              vps = 1'b1;
            end else if (hdr[4:0] == AvcTypeSps &&
                         (prof == 8'd44 || prof == 8'd66 || prof == 8'd77 ||
                          prof == 8'd88 || prof == 8'd100 || prof == 8'd110 ||
                          prof == 8'd122 || prof == 8'd244)) begin
              sps = 1'b1;
            end
          end
        end
      end
    end
    if (last) begin
      kind = vps ? CODEC_H265 : (sps ? CODEC_H264 : CODEC_UNKNOWN);
      pending.push_back(kind);
      clear_state();
    end
  endfunction

  // Called for every accepted output beat.
  task check_verdict(logic [1:0] got);
    codec_kind_e want;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("verdict %0d with no packet pending", got));
    end else begin
      want = pending.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf("codec_kind %0d, expected %0d (%s)", got, want, want.name()));
      end
    end
  endtask
endclass

module annexb_codec_sniffer_test;
  import acs_pkg::*;

  logic clk_i;
  logic rst_ni;

  acs_in_if  in_if ();
  acs_out_if out_if ();

  annexb_codec_sniffer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  verdict_board board;

  // Idle odds in percent, changed per phase.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned beats_sent;

  // Profile bytes the SPS check accepts.
  byte_t listed_profiles[8] = '{8'd44, 8'd66, 8'd77, 8'd88, 8'd100, 8'd110, 8'd122, 8'd244};

  // Directed packets as {last_byte, data_byte}:
  //   4-byte start code with a VPS header          -> H.265
  //   3-byte start code, SPS header, profile 100   -> H.264
  //   SPS-looking header with the forbidden bit    -> unknown
  //   five-byte packet: start code only in tail    -> unknown
  //   one-byte packet                              -> unknown
  logic [8:0] directed_beats[24] = '{
    9'h000, 9'h000, 9'h000, 9'h001, 9'h040, 9'h1FF,
    9'h000, 9'h000, 9'h001, 9'h067, 9'h064, 9'h100,
    9'h000, 9'h000, 9'h001, 9'h0E7, 9'h02C, 9'h1FF,
    9'h0FF, 9'h000, 9'h000, 9'h001, 9'h140,
    9'h100
  };

  // 2-unit clock period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run (~1.5k beats, heavy stalls).
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: ready is redrawn at each falling edge per the sink idle odds.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Output monitor: a verdict beat is taken at the rising edge.
  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      board.check_verdict(out_if.codec_kind);
    end
  end

  // Byte biased toward 00 and 01 so partial and broken start codes show up.
  function automatic byte_t noise_byte();
    byte_t b;
    case ($urandom_range(3))
      0:       b = 8'h00;
      1:       b = StartByte;
      default: b = byte_t'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Drive one input beat; random gaps ahead of it, held until ready.
  task automatic send_byte(byte_t b, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.note_byte(b, last);
    beats_sent++;
  endtask

  // Mostly packets built from start code + header + profile segments with
  // random filler; the rest is pure noise. Trailing filler of 0..4 bytes
  // lands some start codes in the tail positions.
  task automatic send_random_packet();
    byte_t       pkt[$];
    byte_t       hdr;
    int unsigned segs;
    if ($urandom_range(99) < 80) begin
      segs = $urandom_range(1, 3);
      repeat (segs) begin
        repeat ($urandom_range(0, 3)) pkt.push_back(noise_byte());
        if ($urandom_range(1) != 0) pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(StartByte);
        case ($urandom_range(6))
          0, 1:    hdr = {1'b0, HevcTypeVps, 1'($urandom_range(1))};
          2, 3:    hdr = {1'b0, 2'($urandom_range(3)), AvcTypeSps};
          4:       hdr = {1'b1, HevcTypeVps, 1'($urandom_range(1))};
          5:       hdr = {1'b1, 2'($urandom_range(3)), AvcTypeSps};
          default: hdr = byte_t'($urandom_range(255));
        endcase
        pkt.push_back(hdr);
        if ($urandom_range(3) != 0) begin
          pkt.push_back(listed_profiles[$urandom_range(7)]);
        end else begin
          pkt.push_back(byte_t'($urandom_range(255)));
        end
        repeat ($urandom_range(0, 4)) pkt.push_back(noise_byte());
      end
    end else begin
      repeat ($urandom_range(1, 12)) pkt.push_back(noise_byte());
    end
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Sender holds off until every verdict has been read.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    board           = new();
    beats_sent      = 0;
    src_idle_pct    = 13;
    sink_idle_pct   = 58;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Phase 1: light sender gaps, heavy receiver stalls.
    foreach (directed_beats[i]) send_byte(directed_beats[i][7:0], directed_beats[i][8]);
    while (beats_sent < 470) send_random_packet();
    drain();

    // Phase 2: roles swapped.
    src_idle_pct  = 58;
    sink_idle_pct = 13;
    while (beats_sent < 940) send_random_packet();
    drain();

    // Phase 3: full rate on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (beats_sent < 1400) send_random_packet();
    drain();

    // The verdict comes from the output register; the extra wait catches any stray beat.
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/acs_pkg.sv
rtl/acs_in_if.sv
rtl/acs_out_if.sv
rtl/annexb_codec_sniffer.sv
sim/annexb_codec_sniffer_test.sv
